// ----- rtl/core/tfr_pkg.sv -----
// Shared widths and types for the triangle tangent frame core.
package tfr_pkg;

  localparam int POS_W      = 32;               // vertex position, Q16.16
  localparam int TEX_W      = 24;               // texture coordinate, Q8.16
  localparam int FRAC_W     = 14;               // output fraction bits
  localparam int OUT_W      = FRAC_W + 2;       // output word, Q2.14
  localparam int EDGE_W     = POS_W + 1;        // edge, signed
  localparam int DTEX_W     = TEX_W + 1;        // uv delta, signed
  localparam int MUL_W      = 32;               // serial multiplier operand
  localparam int PROD_W     = 2 * MUL_W;
  localparam int VEC_W      = EDGE_W + DTEX_W;  // cross term, signed
  localparam int MAG_W      = VEC_W - 1;        // cross term magnitude
  localparam int NRM_W      = 31;               // normalised magnitude
  localparam int LEN_W      = PROD_W / 2;       // vector length
  localparam int NUM_W      = NRM_W + FRAC_W + 1;
  localparam int QUO_W      = FRAC_W + 1;

  typedef logic signed [POS_W-1:0]  pos_t;
  typedef logic signed [TEX_W-1:0]  tex_t;
  typedef logic signed [EDGE_W-1:0] edge_t;
  typedef logic signed [DTEX_W-1:0] dtex_t;
  typedef logic signed [VEC_W-1:0]  vec_t;
  typedef logic [MAG_W-1:0]         mag_t;
  typedef logic signed [OUT_W-1:0]  comp_t;

endpackage

// ----- rtl/core/tfr_mul.sv -----
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
module tfr_mul (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tfr_pkg::MUL_W-1:0]  a,
  input  logic [tfr_pkg::MUL_W-1:0]  b,
  output logic                       done,
  output logic [tfr_pkg::PROD_W-1:0] p
);
  import tfr_pkg::*;

  logic [PROD_W-1:0]        acc_r, acc_nxt;
  logic [MUL_W-1:0]         a_r;
  logic [$clog2(MUL_W)-1:0] cnt_r;
  logic                     busy_r, done_r;
  logic [MUL_W:0]           sum;

  always_comb begin
    sum     = {1'b0, acc_r[PROD_W-1:MUL_W]} + (acc_r[0] ? {1'b0, a_r} : '0);
    acc_nxt = {sum, acc_r[MUL_W-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == $clog2(MUL_W)'(MUL_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= {{MUL_W{1'b0}}, b};
      a_r   <= a;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
    end
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

// ----- rtl/core/tfr_sqrt.sv -----
// Digit-by-digit integer square root, one root bit per cycle.
module tfr_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [tfr_pkg::PROD_W-1:0] x,
  output logic                       done,
  output logic [tfr_pkg::LEN_W-1:0]  root
);
  import tfr_pkg::*;

  logic [PROD_W-1:0]        x_r;
  logic [LEN_W+2:0]         rem_r, rem_sh, trial;
  logic [LEN_W-1:0]         root_r;
  logic [$clog2(LEN_W)-1:0] cnt_r;
  logic                     busy_r, done_r, take;

  always_comb begin
    rem_sh = {rem_r[LEN_W:0], x_r[PROD_W-1 -: 2]};
    trial  = {1'b0, root_r, 2'b01};
    take   = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == $clog2(LEN_W)'(LEN_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= x;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      x_r    <= {x_r[PROD_W-3:0], 2'b00};
      rem_r  <= take ? rem_sh - trial : rem_sh;
      root_r <= {root_r[LEN_W-2:0], take};
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ----- rtl/core/tfr_div.sv -----
// Restoring divider, one quotient bit per cycle.
module tfr_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [tfr_pkg::NUM_W-1:0] num,
  input  logic [tfr_pkg::LEN_W-1:0] den,
  output logic                      done,
  output logic [tfr_pkg::NUM_W-1:0] quo
);
  import tfr_pkg::*;

  logic [NUM_W-1:0]         q_r;
  logic [LEN_W-1:0]         rem_r, den_r;
  logic [LEN_W:0]           rs;
  logic [$clog2(NUM_W)-1:0] cnt_r;
  logic                     busy_r, done_r, take;

  always_comb begin
    rs   = {rem_r, q_r[NUM_W-1]};
    take = rs >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == $clog2(NUM_W)'(NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= take ? LEN_W'(rs - {1'b0, den_r}) : rs[LEN_W-1:0];
      q_r   <= {q_r[NUM_W-2:0], take};
    end
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

// ----- rtl/core/triangle_tangent_frame_core.sv -----
// Top level: per-triangle unit tangent and bitangent from vertex uv.
//
// Vertices arrive one request at a time, three per triangle. The first two
// are held; the third starts the frame computation and produces one result
// request: unit tangent and bitangent in Q2.14 plus a degenerate flag (set,
// with all vectors zero, when the uv determinant or a vector is zero). All
// arithmetic runs through bit-serial units: a shift-add multiplier (14 cross
// products for the determinant and both vectors, then three squares per
// vector), a square root and a divider (three quotients per vector). The
// work on each vector grows with its normalising shift n (0..26); a
// degenerate determinant ends after its two products. The input stalls
// while a triangle is being worked; the result register lets the next
// triangle's first vertices in while a result waits to be taken.
module triangle_tangent_frame_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  tfr_pkg::pos_t         in_pos_x,
  input  tfr_pkg::pos_t         in_pos_y,
  input  tfr_pkg::pos_t         in_pos_z,
  input  tfr_pkg::tex_t         in_tex_u,
  input  tfr_pkg::tex_t         in_tex_v,
  output logic                  out_valid,
  input  logic                  out_stall,
  output tfr_pkg::comp_t        out_tangent_x,
  output tfr_pkg::comp_t        out_tangent_y,
  output tfr_pkg::comp_t        out_tangent_z,
  output tfr_pkg::comp_t        out_bitangent_x,
  output tfr_pkg::comp_t        out_bitangent_y,
  output tfr_pkg::comp_t        out_bitangent_z,
  output logic                  out_degenerate
);
  import tfr_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PROD = 3'd1;
  localparam logic [2:0] S_NORM = 3'd2;
  localparam logic [2:0] S_SQ   = 3'd3;
  localparam logic [2:0] S_SQRT = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  localparam logic [3:0] OP_LAST = 4'd13;

  logic [2:0] state_r;
  logic [1:0] slot_r;
  logic [3:0] op_r;       // cross product index: pair in [3:1], second term in [0]
  logic [1:0] k_r;        // component in the square and divide steps
  logic       vsel_r;     // 0 tangent, 1 bitangent
  logic       degen_r, det_neg_r;

  pos_t  hpos_r [6];
  tex_t  htex_r [4];
  edge_t e1_r [3];
  edge_t e2_r [3];
  dtex_t du1_r, dv1_r, du2_r, dv2_r;
  vec_t  first_r;
  vec_t  vec_r [6];
  mag_t  m_r [3];
  logic  vneg_r [3];
  logic  opsgn_r;
  logic [PROD_W-1:0] sum_r;
  logic [LEN_W-1:0]  len_r;
  comp_t res_r [6];

  logic  mul_start_r, sqrt_start_r, div_start_r;
  logic  mul_done, sqrt_done, div_done;
  logic [PROD_W-1:0] mul_p;
  logic [LEN_W-1:0]  root;
  logic [NUM_W-1:0]  quo;

  logic  out_valid_r;
  comp_t out_r [6];
  logic  out_degen_r;

  logic  in_take;
  pos_t  in_pos [3];
  assign in_pos[0] = in_pos_x;
  assign in_pos[1] = in_pos_y;
  assign in_pos[2] = in_pos_z;

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;

  // operand pick for the cross products
  edge_t op_a;
  dtex_t op_b;
  logic [2:0] pair;
  logic [MUL_W-1:0] mul_a, mul_b;

  always_comb begin
    pair = op_r[3:1];
    op_a = '0;
    op_b = '0;
    case (pair)
      3'd0: begin
        op_a = op_r[0] ? EDGE_W'(du2_r) : EDGE_W'(du1_r);
        op_b = op_r[0] ? dv1_r : dv2_r;
      end
      3'd1, 3'd2, 3'd3: begin
        op_a = op_r[0] ? e2_r[2'(pair - 3'd1)] : e1_r[2'(pair - 3'd1)];
        op_b = op_r[0] ? dv1_r : dv2_r;
      end
      default: begin
        op_a = op_r[0] ? e1_r[2'(pair - 3'd4)] : e2_r[2'(pair - 3'd4)];
        op_b = op_r[0] ? du2_r : du1_r;
      end
    endcase
  end

  always_comb begin
    if (state_r == S_SQ) begin
      mul_a = MUL_W'(m_r[k_r][NRM_W-1:0]);
      mul_b = MUL_W'(m_r[k_r][NRM_W-1:0]);
    end else begin
      mul_a = MUL_W'(op_a[EDGE_W-1] ? -op_a : op_a);
      mul_b = MUL_W'(op_b[DTEX_W-1] ? -op_b : op_b);
    end
  end

  tfr_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start_r),
    .a(mul_a), .b(mul_b), .done(mul_done), .p(mul_p)
  );

  tfr_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sqrt_start_r),
    .x(sum_r), .done(sqrt_done), .root(root)
  );

  logic [NUM_W-1:0] div_num;
  assign div_num = {1'b0, m_r[k_r][NRM_W-1:0], {FRAC_W{1'b0}}}
                 + NUM_W'(len_r[LEN_W-1:1]);

  tfr_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start_r),
    .num(div_num), .den(len_r), .done(div_done), .quo(quo)
  );

  // signed product and the two-term difference
  vec_t sprod, diff;
  always_comb begin
    sprod = opsgn_r ? -vec_t'({1'b0, mul_p[MAG_W-1:0]}) : vec_t'({1'b0, mul_p[MAG_W-1:0]});
    diff  = first_r - sprod;
  end

  // normalising shift test
  logic any_big, all_zero;
  always_comb begin
    any_big  = 1'b0;
    all_zero = 1'b1;
    for (int k = 0; k < 3; k++) begin
      if (m_r[k][MAG_W-1:NRM_W] != '0) any_big = 1'b1;
      if (m_r[k] != '0) all_zero = 1'b0;
    end
  end

  // quotient with sign applied
  comp_t qs;
  always_comb begin
    qs = {1'b0, quo[QUO_W-1:0]};
    if (vneg_r[k_r] ^ det_neg_r) qs = -qs;
  end

  logic out_free;
  assign out_free = !out_valid_r || !out_stall;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      slot_r       <= '0;
      op_r         <= '0;
      k_r          <= '0;
      vsel_r       <= 1'b0;
      degen_r      <= 1'b0;
      mul_start_r  <= 1'b0;
      sqrt_start_r <= 1'b0;
      div_start_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      mul_start_r  <= 1'b0;
      sqrt_start_r <= 1'b0;
      div_start_r  <= 1'b0;
      if (state_r == S_EMIT && out_free) out_valid_r <= 1'b1;
      else if (!out_stall)               out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_take) begin
            if (slot_r == 2'd2) begin
              slot_r      <= '0;
              op_r        <= '0;
              degen_r     <= 1'b0;
              vsel_r      <= 1'b0;
              mul_start_r <= 1'b1;
              state_r     <= S_PROD;
            end else begin
              slot_r <= slot_r + 2'd1;
            end
          end
        end
        S_PROD: begin
          if (mul_done) begin
            if (op_r == OP_LAST) begin
              state_r <= degen_r ? S_EMIT : S_NORM;
            end else begin
              if (op_r == 4'd1 && diff == '0) begin
                degen_r <= 1'b1;
                state_r <= S_EMIT;
              end else begin
                mul_start_r <= 1'b1;
              end
              op_r <= op_r + 4'd1;
            end
          end
        end
        S_NORM: begin
          if (all_zero) begin
            degen_r <= 1'b1;
            state_r <= S_EMIT;
          end else if (!any_big) begin
            k_r         <= '0;
            mul_start_r <= 1'b1;
            state_r     <= S_SQ;
          end
        end
        S_SQ: begin
          if (mul_done) begin
            if (k_r == 2'd2) begin
              sqrt_start_r <= 1'b1;
              state_r      <= S_SQRT;
            end else begin
              k_r         <= k_r + 2'd1;
              mul_start_r <= 1'b1;
            end
          end
        end
        S_SQRT: begin
          if (sqrt_done) begin
            if (root == '0) begin
              degen_r <= 1'b1;
              state_r <= S_EMIT;
            end else begin
              k_r         <= '0;
              div_start_r <= 1'b1;
              state_r     <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (k_r == 2'd2) begin
              if (!vsel_r) begin
                vsel_r  <= 1'b1;
                state_r <= S_NORM;
              end else begin
                state_r <= S_EMIT;
              end
            end else begin
              k_r         <= k_r + 2'd1;
              div_start_r <= 1'b1;
            end
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_take) begin
      if (slot_r == 2'd2) begin
        for (int k = 0; k < 3; k++) begin
          e1_r[k] <= EDGE_W'(hpos_r[3 + k]) - EDGE_W'(hpos_r[k]);
          e2_r[k] <= EDGE_W'(in_pos[k]) - EDGE_W'(hpos_r[k]);
        end
        du1_r <= DTEX_W'(htex_r[2]) - DTEX_W'(htex_r[0]);
        dv1_r <= DTEX_W'(htex_r[3]) - DTEX_W'(htex_r[1]);
        du2_r <= DTEX_W'(in_tex_u) - DTEX_W'(htex_r[0]);
        dv2_r <= DTEX_W'(in_tex_v) - DTEX_W'(htex_r[1]);
      end else begin
        for (int k = 0; k < 3; k++) begin
          if (slot_r[0]) hpos_r[3 + k] <= in_pos[k];
          else           hpos_r[k]     <= in_pos[k];
        end
        if (slot_r[0]) begin
          htex_r[2] <= in_tex_u;
          htex_r[3] <= in_tex_v;
        end else begin
          htex_r[0] <= in_tex_u;
          htex_r[1] <= in_tex_v;
        end
      end
    end

    if (mul_start_r) opsgn_r <= op_a[EDGE_W-1] ^ op_b[DTEX_W-1];

    if (state_r == S_PROD && mul_done) begin
      if (!op_r[0])          first_r <= sprod;
      else if (op_r == 4'd1) det_neg_r <= diff[VEC_W-1];
      else                   vec_r[op_r[3:1] - 3'd1] <= diff;
    end

    // load magnitudes of the vector about to be normalised
    if ((state_r == S_PROD && mul_done && op_r == OP_LAST) ||
        (state_r == S_DIV && div_done && k_r == 2'd2 && !vsel_r)) begin
      for (int k = 0; k < 3; k++) begin
        vec_t v;
        v = (state_r == S_PROD) ? vec_r[k] : vec_r[3 + k];
        vneg_r[k] <= v[VEC_W-1];
        m_r[k]    <= v[VEC_W-1] ? MAG_W'(-v) : MAG_W'(v);
      end
    end else if (state_r == S_NORM && any_big) begin
      for (int k = 0; k < 3; k++) m_r[k] <= m_r[k] >> 1;
    end

    if (state_r == S_NORM) sum_r <= '0;
    else if (state_r == S_SQ && mul_done) sum_r <= sum_r + mul_p;

    if (state_r == S_SQRT && sqrt_done) len_r <= root;

    if (state_r == S_DIV && div_done) begin
      if (vsel_r) res_r[3'd3 + 3'(k_r)] <= qs;
      else        res_r[k_r]            <= qs;
    end

    if (state_r == S_EMIT && out_free) begin
      for (int k = 0; k < 6; k++) out_r[k] <= degen_r ? '0 : res_r[k];
      out_degen_r <= degen_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_tangent_x   = out_r[0];
  assign out_tangent_y   = out_r[1];
  assign out_tangent_z   = out_r[2];
  assign out_bitangent_x = out_r[3];
  assign out_bitangent_y = out_r[4];
  assign out_bitangent_z = out_r[5];
  assign out_degenerate  = out_degen_r;

endmodule
